// File: rtl/pcbp_pkg.sv
package pcbp_pkg;

  // Fixed field widths of the request and result ports.
  localparam int KIND_W       = 2;
  localparam int SYMBOL_W     = 8;
  localparam int CODE_FIELD_W = 32;
  localparam int LEN_FIELD_W  = 6;
  localparam int BYTE_W       = 8;

  // Defaults for the top-level parameters.
  localparam int MAX_CODE_BITS_DEFAULT = 32;
  localparam int SYMBOL_COUNT_DEFAULT  = 256;

  // Depth of the command queue between the front and the back.
  localparam int CMD_QUEUE_DEPTH = 2;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  // One command handed from the front to the back.
  typedef struct packed {
    logic                    flush;
    logic [CODE_FIELD_W-1:0] code;
    logic [LEN_FIELD_W-1:0]  len;
  } cmd_t;

endpackage

// File: rtl/prefix_code_bit_packer.sv
// Channel   Handshake        Accepted when       Payload
// request   push / full      push && !full       kind, symbol, code_value, code_length
// result    empty / pop      pop && !empty       packed_byte, last, stream_end
//
// The front reads the code table for an encode and registers each encode or
// flush. In the back an encode request merges its code into the bit
// accumulator and then emits each completed byte in turn, taking no new
// command while a complete byte is pending; a flush emits the padded partial
// byte, if any. The back's byte emission loop sets the sustained rate.
// Reset clears the pending bits, the command queue and the result register;
// the code table is undefined until loaded. A stalled result only stops
// the back; the front keeps taking requests until the queue and its stage fill.
module prefix_code_bit_packer #(
  parameter int MAX_CODE_BITS = pcbp_pkg::MAX_CODE_BITS_DEFAULT,
  parameter int SYMBOL_COUNT  = pcbp_pkg::SYMBOL_COUNT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [pcbp_pkg::KIND_W-1:0]       kind,
  input  logic [pcbp_pkg::SYMBOL_W-1:0]     symbol,
  input  logic [pcbp_pkg::CODE_FIELD_W-1:0] code_value,
  input  logic [pcbp_pkg::LEN_FIELD_W-1:0]  code_length,
  output logic                              empty,
  input  logic                              pop,
  output logic [pcbp_pkg::BYTE_W-1:0]       packed_byte,
  output logic                              last,
  output logic                              stream_end
);

  // Commands travel from the front through a short queue to the back.
  logic           front_valid;
  pcbp_pkg::cmd_t front_cmd;
  logic           queue_full;
  logic           queue_valid;
  pcbp_pkg::cmd_t queue_cmd;
  logic           back_pop;

  // The front applies table loads, reads the table for encodes and
  // forwards encodes and flushes; ignored requests leave no trace.
  pcbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .SYMBOL_COUNT  (SYMBOL_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .symbol      (symbol),
    .code_value  (code_value),
    .code_length (code_length),
    .cmd_valid   (front_valid),
    .cmd         (front_cmd),
    .cmd_full    (queue_full)
  );

  pcbp_queue #(
    .DEPTH (pcbp_pkg::CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_cmd),
    .q_full  (queue_full),
    .rd_en   (back_pop),
    .q_valid (queue_valid),
    .rd_data (queue_cmd)
  );

  // The back owns the bit accumulator and the result register.
  pcbp_back #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (queue_valid),
    .cmd         (queue_cmd),
    .cmd_pop     (back_pop),
    .empty       (empty),
    .pop         (pop),
    .packed_byte (packed_byte),
    .last        (last),
    .stream_end  (stream_end)
  );

endmodule

// File: rtl/pcbp_front.sv
module pcbp_front #(
  parameter int MAX_CODE_BITS = pcbp_pkg::MAX_CODE_BITS_DEFAULT,
  parameter int SYMBOL_COUNT  = pcbp_pkg::SYMBOL_COUNT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [pcbp_pkg::KIND_W-1:0]        kind,
  input  logic [pcbp_pkg::SYMBOL_W-1:0]      symbol,
  input  logic [pcbp_pkg::CODE_FIELD_W-1:0]  code_value,
  input  logic [pcbp_pkg::LEN_FIELD_W-1:0]   code_length,
  output logic                               cmd_valid,
  output pcbp_pkg::cmd_t                     cmd,
  input  logic                               cmd_full
);

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
  localparam int SYMBOL_W_P1 = pcbp_pkg::SYMBOL_W + 1;

  logic [MAX_CODE_BITS-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]         len_mem  [SYMBOL_COUNT];

  logic [MAX_CODE_BITS-1:0] rd_code;
  logic [LEN_W-1:0]         rd_len;
  logic                     stage_valid;
  logic                     stage_valid_next;
  logic                     stage_flush;

  logic                     accept;
  logic                     sym_ok;
  logic                     do_load;
  logic                     do_encode;
  logic                     do_flush;
  logic                     advance;
  logic [LEN_W-1:0]         len_sat;
  logic [MAX_CODE_BITS-1:0] code_masked;

  assign advance = stage_valid && !cmd_full;
  assign full    = stage_valid && cmd_full;
  assign accept  = push && !full;
  assign sym_ok  = {1'b0, symbol} < (SYMBOL_W_P1)'(SYMBOL_COUNT);

  assign do_load   = accept && sym_ok && (kind == pcbp_pkg::KIND_LOAD);
  assign do_encode = accept && sym_ok && (kind == pcbp_pkg::KIND_ENCODE);
  assign do_flush  = accept && (kind == pcbp_pkg::KIND_FLUSH);

  // Lengths above the table width saturate; bits above the length are dropped.
  always_comb begin
    if ({1'b0, code_length} > (pcbp_pkg::LEN_FIELD_W + 1)'(MAX_CODE_BITS)) begin
      len_sat = LEN_W'(MAX_CODE_BITS);
    end else begin
      len_sat = code_length[LEN_W-1:0];
    end
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      code_masked[i] = code_value[i] && (i < int'(len_sat));
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_mem[symbol[IDX_W-1:0]] <= code_masked;
      len_mem[symbol[IDX_W-1:0]]  <= len_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (do_encode) begin
      rd_code <= code_mem[symbol[IDX_W-1:0]];
      rd_len  <= len_mem[symbol[IDX_W-1:0]];
    end
  end

  always_comb begin
    if (do_encode || do_flush) begin
      stage_valid_next = 1'b1;
    end else if (advance) begin
      stage_valid_next = 1'b0;
    end else begin
      stage_valid_next = stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_encode || do_flush) begin
      stage_flush <= do_flush;
    end
  end

  assign cmd_valid  = stage_valid;
  assign cmd.flush  = stage_flush;
  assign cmd.code   = pcbp_pkg::CODE_FIELD_W'(rd_code);
  assign cmd.len    = pcbp_pkg::LEN_FIELD_W'(rd_len);

endmodule

// File: rtl/pcbp_queue.sv
module pcbp_queue #(
  parameter int DEPTH = pcbp_pkg::CMD_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  pcbp_pkg::cmd_t wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output logic           q_valid,
  output pcbp_pkg::cmd_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pcbp_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/pcbp_back.sv
module pcbp_back #(
  parameter int MAX_CODE_BITS = pcbp_pkg::MAX_CODE_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  pcbp_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [pcbp_pkg::BYTE_W-1:0] packed_byte,
  output logic                        last,
  output logic                        stream_end
);

  // The accumulator holds up to seven pending bits plus one whole code.
  localparam int ACC_W = MAX_CODE_BITS + pcbp_pkg::BYTE_W - 1;
  localparam int REM_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_next;

  logic                        out_valid;
  logic [pcbp_pkg::BYTE_W-1:0] out_byte;
  logic                        out_last;
  logic                        out_end;

  logic                        slot_free;
  logic                        busy;
  logic                        emit;
  logic                        take;
  logic                        load_out;
  logic [pcbp_pkg::BYTE_W-1:0] byte_next;
  logic                        last_next;
  logic                        end_next;
  logic [ACC_W-1:0]            hi_shift;
  logic [ACC_W-1:0]            pad_shift;
  logic [REM_W-1:0]            cmd_len;

  assign slot_free = !out_valid || pop;
  assign busy      = rem >= REM_W'(pcbp_pkg::BYTE_W);
  assign emit      = busy && slot_free;
  assign take      = cmd_valid && !busy && (!cmd.flush || slot_free);
  assign cmd_pop   = take;
  assign cmd_len   = cmd.len[REM_W-1:0];

  assign hi_shift  = acc >> (rem - REM_W'(pcbp_pkg::BYTE_W));
  assign pad_shift = acc << (REM_W'(pcbp_pkg::BYTE_W) - rem);

  always_comb begin
    acc_next  = acc;
    rem_next  = rem;
    load_out  = 1'b0;
    byte_next = hi_shift[pcbp_pkg::BYTE_W-1:0];
    last_next = 1'b0;
    end_next  = 1'b0;
    if (emit) begin
      // Oldest complete byte is the top eight of the valid bits.
      load_out  = 1'b1;
      rem_next  = rem - REM_W'(pcbp_pkg::BYTE_W);
      last_next = rem_next < REM_W'(pcbp_pkg::BYTE_W);
    end else if (take && cmd.flush) begin
      if (rem != '0) begin
        load_out  = 1'b1;
        byte_next = pad_shift[pcbp_pkg::BYTE_W-1:0];
        last_next = 1'b1;
        end_next  = 1'b1;
      end
      rem_next = '0;
    end else if (take) begin
      acc_next = (acc << cmd_len) | ACC_W'(cmd.code[MAX_CODE_BITS-1:0]);
      rem_next = rem + cmd_len;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (load_out) begin
      out_byte <= byte_next;
      out_last <= last_next;
      out_end  <= end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      rem <= rem_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty       = !out_valid;
  assign packed_byte = out_byte;
  assign last        = out_last;
  assign stream_end  = out_end;

endmodule

// File: tb/tb_prefix_code_bit_packer.sv
module tb_prefix_code_bit_packer;
  import pcbp_pkg::*;

  // The reserved request kind has no name in the package. The block must drop it.
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

  // The byte size that the packer emits, and the saturation point for code lengths.
  localparam int BYTE_BITS = 8;
  localparam int MAX_BITS  = MAX_CODE_BITS_DEFAULT;

  // The receiver holds pop low for this many cycles once, so that the command
  // queue fills and full is raised.
  localparam int HOLD_CYCLES = 80;

  // Cycles to wait after the last expected byte, in case a late extra byte
  // comes out.
  localparam int DRAIN_CYCLES = 24;

  // Timeout guard. The slowest correct run is far below this: about 470
  // requests, each with a random sender gap, four bytes that each wait out a
  // receiver stall, and the one long hold.
  localparam int CYCLE_LIMIT = 200000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    full;
  logic [KIND_W-1:0]       kind = KIND_LOAD;
  logic [SYMBOL_W-1:0]     symbol = '0;
  logic [CODE_FIELD_W-1:0] code_value = '0;
  logic [LEN_FIELD_W-1:0]  code_length = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [BYTE_W-1:0]       packed_byte;
  logic                    last;
  logic                    stream_end;

  prefix_code_bit_packer DUT (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .symbol      (symbol),
    .code_value  (code_value),
    .code_length (code_length),
    .empty       (empty),
    .pop         (pop),
    .packed_byte (packed_byte),
    .last        (last),
    .stream_end  (stream_end)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // One byte that the packer should produce, with its two flags.
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              is_last;
    logic              is_end;
  } packed_byte_t;

  packed_byte_t expected_bytes[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;

  // This is the testbench's own copy of the packer state. It covers the code table
  // (codes are stored with their bits already masked and their lengths already
  // saturated) and the partial byte that has not been emitted yet.
  logic [CODE_FIELD_W-1:0] shadow_code[256];
  logic [LEN_FIELD_W-1:0]  shadow_len[256];
  logic [6:0]              partial_bits = '0;
  logic [2:0]              partial_count = '0;

  // Symbols that have a table entry. An encode request is only ever issued for
  // one of these, because an entry that was never written holds an undefined value.
  logic [SYMBOL_W-1:0] loaded_syms[$];
  bit                  is_loaded[256];

  // These switches control the random idling on each side and the one long hold.
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  bit hold_request = 1'b0;

  // This task works out the bytes that one accepted request should produce.
  task automatic predict_packed_bytes(input logic [KIND_W-1:0] k,
                                      input logic [SYMBOL_W-1:0] sym,
                                      input logic [CODE_FIELD_W-1:0] val,
                                      input logic [LEN_FIELD_W-1:0] len);
    logic [63:0]  acc;
    logic [63:0]  mask;
    logic [63:0]  shifted;
    int           n;
    int           total;
    int           nbytes;
    packed_byte_t r;
    if (int'(sym) >= SYMBOL_COUNT_DEFAULT && (k == KIND_LOAD || k == KIND_ENCODE))
      return;
    case (k)
      KIND_LOAD: begin
        // Lengths above the maximum saturate, and code bits above the length are dropped.
        n = (int'(len) > MAX_BITS) ? MAX_BITS : int'(len);
        mask = (64'd1 << n) - 64'd1;
        shadow_code[sym] = val & mask[31:0];
        shadow_len[sym] = LEN_FIELD_W'(n);
      end
      KIND_ENCODE: begin
        // Append the code after the partial bits. Every complete byte is then
        // taken from the top of the accumulated bits.
        n = int'(shadow_len[sym]);
        acc = ({57'd0, partial_bits} << n) | {32'd0, shadow_code[sym]};
        total = int'(partial_count) + n;
        nbytes = total / BYTE_BITS;
        for (int i = 0; i < nbytes; i++) begin
          shifted = acc >> (total - BYTE_BITS * (i + 1));
          r.data = shifted[7:0];
          r.is_last = (i == nbytes - 1);
          r.is_end = 1'b0;
          expected_bytes.push_back(r);
        end
        total = total - nbytes * BYTE_BITS;
        mask = (64'd1 << total) - 64'd1;
        acc = acc & mask;
        partial_bits = acc[6:0];
        partial_count = 3'(total);
      end
      KIND_FLUSH: begin
        // A flush pads the partial byte with zeros on the right. When no bits
        // are pending, a flush produces nothing.
        if (partial_count != 3'd0) begin
          shifted = {57'd0, partial_bits} << (BYTE_BITS - int'(partial_count));
          r.data = shifted[7:0];
          r.is_last = 1'b1;
          r.is_end = 1'b1;
          expected_bytes.push_back(r);
          partial_bits = '0;
          partial_count = '0;
        end
      end
      default: begin
        // The reserved kind is dropped by the block and has no effect.
      end
    endcase
  endtask

  // This task offers one request and waits until the block accepts it.
  // Acceptance is judged on values sampled at the rising edge. The inputs
  // change only at the falling edge. After acceptance the sender sometimes
  // idles for a random burst.
  task automatic send_request(input logic [KIND_W-1:0] k,
                              input logic [SYMBOL_W-1:0] sym,
                              input logic [CODE_FIELD_W-1:0] val,
                              input logic [LEN_FIELD_W-1:0] len);
    push <= 1'b1;
    kind <= k;
    symbol <= sym;
    code_value <= val;
    code_length <= len;
    do @(posedge clk); while (full);
    predict_packed_bytes(k, sym, val, len);
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  // This task writes one table entry and records the symbol as safe to encode.
  task automatic load_entry(input logic [SYMBOL_W-1:0] sym,
                            input logic [CODE_FIELD_W-1:0] val,
                            input logic [LEN_FIELD_W-1:0] len);
    send_request(KIND_LOAD, sym, val, len);
    if (!is_loaded[sym]) begin
      is_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // This task makes one random request. Most requests are encodes of loaded
  // symbols; the rest are reloads, flushes and reserved kinds. Code lengths
  // cover zero, short codes, long codes, and values past the saturation point.
  // The fields that a kind does not use carry random junk.
  task automatic random_request();
    int                  pick;
    int                  lpick;
    logic [LEN_FIELD_W-1:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 15 || loaded_syms.size() == 0) begin
      lpick = $urandom_range(0, 99);
      if (lpick < 5)
        len = '0;
      else if (lpick < 15)
        len = LEN_FIELD_W'($urandom_range(MAX_BITS + 1, 63));
      else if (lpick < 50)
        len = LEN_FIELD_W'($urandom_range(1, 8));
      else
        len = LEN_FIELD_W'($urandom_range(9, MAX_BITS));
      load_entry(SYMBOL_W'($urandom_range(0, 255)), $urandom, len);
    end else if (pick < 85) begin
      send_request(KIND_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                   $urandom, LEN_FIELD_W'($urandom_range(0, 63)));
    end else if (pick < 95) begin
      send_request(KIND_FLUSH, SYMBOL_W'($urandom_range(0, 255)), $urandom,
                   LEN_FIELD_W'($urandom_range(0, 63)));
    end else begin
      send_request(KIND_RESERVED, SYMBOL_W'($urandom_range(0, 255)), $urandom,
                   LEN_FIELD_W'($urandom_range(0, 63)));
    end
  endtask

  // This test covers the field extremes and each special case: an empty flush,
  // the reserved kind, a zero-length code, stray code bits, saturated lengths,
  // and a 32-bit code that lands on seven pending bits and yields four bytes.
  task automatic test_directed_cases();
    send_request(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(KIND_RESERVED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    load_entry(8'h00, 32'hFFFF_FFFF, 6'd0);
    load_entry(8'hFF, 32'hFFFF_FFFF, 6'd32);
    load_entry(8'h01, 32'h0000_0001, 6'd1);
    load_entry(8'h02, 32'hFFFF_FFFF, 6'd63);
    load_entry(8'h03, 32'hDEAD_BEEF, 6'd5);
    load_entry(8'h80, 32'h0000_0000, 6'd33);
    load_entry(8'h55, 32'h0000_02AA, 6'd10);
    send_request(KIND_ENCODE, 8'h00, 32'h0, 6'd0);
    repeat (7) send_request(KIND_ENCODE, 8'h01, 32'h0, 6'd0);
    send_request(KIND_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(KIND_ENCODE, 8'h03, 32'h0, 6'd0);
    send_request(KIND_ENCODE, 8'h55, 32'h0, 6'd0);
    send_request(KIND_ENCODE, 8'h80, 32'h0, 6'd0);
    send_request(KIND_ENCODE, 8'h02, 32'h0, 6'd0);
    send_request(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  // This test sends a long random stream with idling on both sides.
  task automatic test_random_stream();
    repeat (275) random_request();
  endtask

  // This test has the receiver stop for a long stretch while the sender keeps
  // pushing encodes without gaps. The command queue has to fill up, and full
  // has to hold the sender off without losing or repeating a byte.
  task automatic test_result_backpressure();
    sender_gaps = 1'b0;
    hold_request = 1'b1;
    repeat (40)
      send_request(KIND_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                   $urandom, LEN_FIELD_W'($urandom_range(0, 63)));
    sender_gaps = 1'b1;
  endtask

  // This test closes the run at full rate on both sides, with no idling at all.
  task automatic test_full_rate();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    repeat (130) random_request();
    send_request(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  // The receiver sets pop at each falling edge. It mixes random stall bursts
  // with the one long hold, which it counts itself.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Each byte that is taken is checked against the oldest expected byte.
  always @(posedge clk) begin
    packed_byte_t exp_byte;
    if (!rst && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected packed_byte %02h (last %0b, stream_end %0b)",
               packed_byte, last, stream_end);
        mismatch_count++;
      end else begin
        exp_byte = expected_bytes.pop_front();
        if (packed_byte !== exp_byte.data) begin
          $error("packed_byte: expected %02h, got %02h", exp_byte.data, packed_byte);
          mismatch_count++;
        end
        if (last !== exp_byte.is_last) begin
          $error("last: expected %0b, got %0b", exp_byte.is_last, last);
          mismatch_count++;
        end
        if (stream_end !== exp_byte.is_end) begin
          $error("stream_end: expected %0b, got %0b", exp_byte.is_end, stream_end);
          mismatch_count++;
        end
      end
    end
  end

  // This process ends the run if the block hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("prefix_code_bit_packer verification failed");
    $finish;
  end

  initial begin : main
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_random_stream();
    test_result_backpressure();
    test_full_rate();
    push <= 1'b0;

    // Wait until every expected byte has come out, then give the block a short
    // extra window in which any surplus byte would be caught.
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("prefix_code_bit_packer verification clean");
    else
      $display("prefix_code_bit_packer verification failed");
    $finish;
  end

endmodule
